@@ sv/binomial_lattice_slalom_pricer_assert.svh @@
// Assertion helpers used by the pricer controller.
// Both expect clk and rst_n in scope.
`ifndef BINOMIAL_LATTICE_SLALOM_PRICER_ASSERT_SVH
`define BINOMIAL_LATTICE_SLALOM_PRICER_ASSERT_SVH

`define BLSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BLSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/blsp_pkg.sv @@
`default_nettype none

package blsp_pkg;

    localparam int DEFAULT_MAX_DATES = 16;
    localparam int DEFAULT_MAX_STEPS = 1023;

    localparam int CFG_W = 48;
    localparam int CFG_AW = 3;

    localparam logic [1:0] OP_APPEND  = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_SPOT      = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_BARRIER   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_UP        = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_DOWN_SQ   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_PROB_UP   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_DISCOUNT  = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_STEPS     = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_STEP_DAYS = 3'd7;

    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] PAYOUT = 32'd1677721600;

    typedef struct packed {
        logic load_spot;
        logic row_we;
        logic term_dir_load;
        logic mul_start;
        logic mul_sel_dsq;
        logic mul_take;
        logic mul_hold;
        logic node_adv;
        logic prem_we;
        logic prem_term;
        logic win_load;
        logic hit_clear;
        logic scan_cmp;
        logic load_row;
        logic up_load;
        logic blend_m1;
        logic blend_m2;
        logic res_load;
        logic res_err;
        logic date_we;
    } blsp_cmd_t;

    typedef struct packed {
        logic scan_match;
    } blsp_status_t;

endpackage

`default_nettype wire

@@ sv/blsp_ram.sv @@
`default_nettype none

module blsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/blsp_ctrl.sv @@
`default_nettype none

module blsp_ctrl #(
    parameter int MAX_DATES = 16,
    parameter int MAX_STEPS = 1023,
    localparam int SW = $clog2(MAX_STEPS + 1),
    localparam int DAW = (MAX_DATES > 1) ? $clog2(MAX_DATES) : 1,
    localparam int DCW = $clog2(MAX_DATES + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [1:0]            opcode,
    output logic                       busy,
    output logic                       done,
    input  wire logic [SW-1:0]         nsteps,
    input  wire blsp_pkg::blsp_status_t status,
    output blsp_pkg::blsp_cmd_t        cmd,
    output logic      [SW-1:0]         row_addr,
    output logic      [SW-1:0]         prem_raddr,
    output logic      [SW-1:0]         prem_waddr,
    output logic      [DAW-1:0]        date_waddr,
    output logic      [DAW-1:0]        date_raddr
);

    import blsp_pkg::*;

    `include "binomial_lattice_slalom_pricer_assert.svh"

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TERM_DIR,
        ST_BUILD_CHK,
        ST_BUILD_M1,
        ST_BUILD_M2,
        ST_TERM_M1,
        ST_TERM_M2,
        ST_ROW_START,
        ST_WIN,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_ROW_LD,
        ST_ROW_LD2,
        ST_N_RD,
        ST_N_M1,
        ST_N_M2,
        ST_N_WR,
        ST_OUT_RD,
        ST_OUT_ST
    } state_t;

    state_t         state_reg, state_next;
    logic [SW-1:0]  n_reg, n_next;
    logic [SW-1:0]  i_reg, i_next;
    logic [DAW-1:0] j_reg, j_next;
    logic [DCW-1:0] count_reg, count_next;
    logic           done_reg, done_next;
    logic [DCW-1:0] count_last;

    assign count_last = count_reg - DCW'(1);

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        i_next = i_reg;
        j_next = j_reg;
        count_next = count_reg;
        done_next = 1'b0;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode)
                        OP_APPEND:
                        begin
                            if (count_reg < DCW'(MAX_DATES))
                            begin
                                cmd.date_we = 1'b1;
                                count_next = count_reg + DCW'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_COMPUTE:
                        begin
                            if (count_reg == '0)
                            begin
                                cmd.res_load = 1'b1;
                                cmd.res_err = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                cmd.load_spot = 1'b1;
                                cmd.row_we = 1'b1;
                                n_next = '0;
                                state_next = ST_TERM_DIR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TERM_DIR:
            begin
                cmd.term_dir_load = 1'b1;
                state_next = ST_BUILD_CHK;
            end
            ST_BUILD_CHK:
            begin
                if (n_reg == nsteps)
                begin
                    i_next = '0;
                    state_next = ST_TERM_M1;
                end
                else
                begin
                    state_next = ST_BUILD_M1;
                end
            end
            ST_BUILD_M1:
            begin
                cmd.mul_start = 1'b1;
                state_next = ST_BUILD_M2;
            end
            ST_BUILD_M2:
            begin
                cmd.mul_take = 1'b1;
                cmd.row_we = 1'b1;
                n_next = n_reg + SW'(1);
                state_next = ST_BUILD_CHK;
            end
            ST_TERM_M1:
            begin
                cmd.prem_we = 1'b1;
                cmd.prem_term = 1'b1;
                cmd.mul_start = 1'b1;
                cmd.mul_sel_dsq = 1'b1;
                state_next = ST_TERM_M2;
            end
            ST_TERM_M2:
            begin
                cmd.mul_take = 1'b1;
                if (i_reg == nsteps)
                begin
                    n_next = nsteps;
                    state_next = ST_ROW_START;
                end
                else
                begin
                    i_next = i_reg + SW'(1);
                    state_next = ST_TERM_M1;
                end
            end
            ST_ROW_START:
            begin
                if (n_reg == '0)
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    n_next = n_reg - SW'(1);
                    state_next = ST_WIN;
                end
            end
            ST_WIN:
            begin
                cmd.win_load = 1'b1;
                cmd.hit_clear = 1'b1;
                j_next = '0;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                cmd.scan_cmp = 1'b1;
                if (status.scan_match || (DCW'(j_reg) == count_last))
                begin
                    state_next = ST_ROW_LD;
                end
                else
                begin
                    j_next = j_reg + DAW'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_ROW_LD:
            begin
                state_next = ST_ROW_LD2;
            end
            ST_ROW_LD2:
            begin
                cmd.load_row = 1'b1;
                cmd.up_load = 1'b1;
                i_next = '0;
                state_next = ST_N_RD;
            end
            ST_N_RD:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel_dsq = 1'b1;
                state_next = ST_N_M1;
            end
            ST_N_M1:
            begin
                cmd.blend_m1 = 1'b1;
                cmd.mul_hold = 1'b1;
                state_next = ST_N_M2;
            end
            ST_N_M2:
            begin
                cmd.blend_m2 = 1'b1;
                state_next = ST_N_WR;
            end
            ST_N_WR:
            begin
                cmd.prem_we = 1'b1;
                cmd.node_adv = 1'b1;
                if (i_reg == n_reg)
                begin
                    state_next = ST_ROW_START;
                end
                else
                begin
                    i_next = i_reg + SW'(1);
                    state_next = ST_N_RD;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_ST;
            end
            ST_OUT_ST:
            begin
                cmd.res_load = 1'b1;
                done_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_BUILD_M2)
        begin
            row_addr = n_reg + SW'(1);
        end
        else if (state_reg == ST_IDLE)
        begin
            row_addr = '0;
        end
        else
        begin
            row_addr = n_reg;
        end
    end

    assign prem_raddr = (state_reg == ST_N_RD) ? (i_reg + SW'(1)) : '0;
    assign prem_waddr = i_reg;
    assign date_waddr = DAW'(count_reg);
    assign date_raddr = (state_reg == ST_SCAN_RD) ? j_reg : DAW'(count_last);

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            count_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next;
            i_reg <= i_next;
            j_reg <= j_next;
            count_reg <= count_next;
            done_reg <= done_next;
        end
    end

    `BLSP_ASSERT_IMP(a_done_idle, done, !busy, "Result strobe while a run is active.")
    `BLSP_ASSERT_IMP(a_count_max, 1'b1, count_reg <= DCW'(MAX_DATES), "Date count overflow.")
    `BLSP_ASSERT_IMP(a_node_in_row, state_reg == ST_N_WR, i_reg <= n_reg, "Node beyond row.")
    `BLSP_ASSERT_NXT(a_compute_busy, start && !busy && opcode == OP_COMPUTE && count_reg != '0,
        busy, "Compute request did not start a run.")

endmodule

`default_nettype wire

@@ sv/blsp_dp.sv @@
`default_nettype none

module blsp_dp #(
    parameter int MAX_DATES = 16,
    parameter int MAX_STEPS = 1023,
    localparam int SW = $clog2(MAX_STEPS + 1),
    localparam int DAW = (MAX_DATES > 1) ? $clog2(MAX_DATES) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [blsp_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [blsp_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic [15:0]                   date_day,
    input  wire logic                          direction,
    input  wire logic [15:0]                   today_day,
    input  wire blsp_pkg::blsp_cmd_t           cmd,
    output blsp_pkg::blsp_status_t             status,
    output logic      [SW-1:0]                 nsteps,
    input  wire logic [SW-1:0]                 row_addr,
    input  wire logic [SW-1:0]                 prem_raddr,
    input  wire logic [SW-1:0]                 prem_waddr,
    input  wire logic [DAW-1:0]                date_waddr,
    input  wire logic [DAW-1:0]                date_raddr,
    output logic      [31:0]                   option_value,
    output logic                               error_flag
);

    import blsp_pkg::*;

    logic [47:0] spot_reg;
    logic [47:0] barrier_reg;
    logic [31:0] up_reg_cfg;
    logic [31:0] dsq_reg;
    logic [31:0] pu_reg;
    logic [31:0] disc_reg;
    logic [9:0]  steps_reg;
    logic [31:0] sdays_reg;

    logic [15:0] today_reg;
    logic [47:0] asset_reg;
    logic [47:0] asset_nx_reg;
    logic [55:0] mp_reg;
    logic [55:0] mq_reg;
    logic        term_dir_reg;
    logic        hit_reg;
    logic        hit_dir_reg;
    logic [47:0] win_lo_reg;
    logic [31:0] up_reg;
    logic [31:0] dn_reg;
    logic [63:0] t1_reg;
    logic [64:0] t2_reg;
    logic [32:0] w_reg;
    logic [31:0] value_reg;
    logic        err_reg;

    logic [31:0]    mul_f;
    logic [79:0]    mul_sum;
    logic [79:0]    mul_shift;
    logic [47:0]    mul_res;
    logic [SW+31:0] win_prod;
    logic [47:0]    win_hi;
    logic [47:0]    date_q;
    logic [32:0]    pd;
    logic [64:0]    blend_sum;
    logic [64:0]    blend_prod;
    logic [31:0]    blend_v;
    logic           surv_term;
    logic           surv_hit;

    logic [47:0] row_wdata;
    logic [47:0] row_rdata;
    logic [31:0] prem_wdata;
    logic [31:0] prem_rdata;
    logic [16:0] date_rdata;

    function automatic logic survives(input logic [47:0] asset, input logic [47:0] barrier,
                                      input logic dir);
        survives = dir ? (asset < barrier) : (asset > barrier);
    endfunction

    assign nsteps = (32'(steps_reg) > 32'(MAX_STEPS)) ? SW'(MAX_STEPS) : SW'(steps_reg);

    assign mul_f = cmd.mul_sel_dsq ? dsq_reg : up_reg_cfg;
    assign mul_sum = {mp_reg, 24'b0} + 80'(mq_reg);
    assign mul_shift = mul_sum >> 30;
    assign mul_res = (|mul_shift[79:48]) ? MASK48 : mul_shift[47:0];

    assign win_prod = (SW+32)'(row_addr) * (SW+32)'(sdays_reg);
    assign win_hi = win_lo_reg + 48'(sdays_reg);
    assign date_q = {16'b0, date_rdata[16:1], 16'b0};
    assign status.scan_match = (date_q >= win_lo_reg) && (date_q < win_hi);

    assign pd = 33'h1_0000_0000 - 33'(pu_reg);
    assign blend_sum = 65'(t1_reg) + t2_reg;
    assign blend_prod = 65'(w_reg) * 65'(disc_reg);
    assign blend_v = blend_prod[63:32];

    assign surv_term = survives(asset_reg, barrier_reg, term_dir_reg);
    assign surv_hit = survives(asset_reg, barrier_reg, hit_dir_reg);

    assign row_wdata = cmd.load_spot ? spot_reg : mul_res;

    always_comb
    begin
        if (cmd.prem_term)
        begin
            prem_wdata = surv_term ? PAYOUT : '0;
        end
        else if (hit_reg && !surv_hit)
        begin
            prem_wdata = '0;
        end
        else
        begin
            prem_wdata = blend_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spot_reg <= '0;
            barrier_reg <= '0;
            up_reg_cfg <= 32'd1073741824;
            dsq_reg <= 32'd1073741824;
            pu_reg <= 32'd2147483648;
            disc_reg <= 32'hFFFF_FFFF;
            steps_reg <= 10'd1;
            sdays_reg <= 32'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SPOT:      spot_reg <= cfg_wdata[47:0];
                CFG_BARRIER:   barrier_reg <= cfg_wdata[47:0];
                CFG_UP:        up_reg_cfg <= cfg_wdata[31:0];
                CFG_DOWN_SQ:   dsq_reg <= cfg_wdata[31:0];
                CFG_PROB_UP:   pu_reg <= cfg_wdata[31:0];
                CFG_DISCOUNT:  disc_reg <= cfg_wdata[31:0];
                CFG_STEPS:     steps_reg <= cfg_wdata[9:0];
                CFG_STEP_DAYS: sdays_reg <= cfg_wdata[31:0];
                default:       spot_reg <= spot_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_spot)
        begin
            asset_reg <= spot_reg;
            today_reg <= today_day;
        end
        else if (cmd.mul_take)
        begin
            asset_reg <= mul_res;
        end
        else if (cmd.load_row)
        begin
            asset_reg <= row_rdata;
        end
        else if (cmd.node_adv)
        begin
            asset_reg <= asset_nx_reg;
        end
        if (cmd.mul_hold)
        begin
            asset_nx_reg <= mul_res;
        end
        if (cmd.mul_start)
        begin
            mp_reg <= 56'(asset_reg[47:24]) * 56'(mul_f);
            mq_reg <= 56'(asset_reg[23:0]) * 56'(mul_f);
        end
        if (cmd.term_dir_load)
        begin
            term_dir_reg <= date_rdata[0];
        end
        if (cmd.win_load)
        begin
            win_lo_reg <= 48'(win_prod) + {16'b0, today_reg, 16'b0};
        end
        if (cmd.hit_clear)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.scan_cmp && status.scan_match)
        begin
            hit_reg <= 1'b1;
            hit_dir_reg <= date_rdata[0];
        end
        if (cmd.up_load)
        begin
            up_reg <= prem_rdata;
        end
        else if (cmd.node_adv)
        begin
            up_reg <= dn_reg;
        end
        if (cmd.blend_m1)
        begin
            dn_reg <= prem_rdata;
            t1_reg <= 64'(pu_reg) * 64'(up_reg);
            t2_reg <= 65'(pd) * 65'(prem_rdata);
        end
        if (cmd.blend_m2)
        begin
            w_reg <= blend_sum[64:32];
        end
        if (cmd.res_load)
        begin
            value_reg <= cmd.res_err ? '0 : prem_rdata;
            err_reg <= cmd.res_err;
        end
    end

    assign option_value = value_reg;
    assign error_flag = err_reg;

    blsp_ram #(
        .WIDTH(48),
        .DEPTH(MAX_STEPS + 1)
    ) u_row_ram (
        .clk  (clk),
        .we   (cmd.row_we),
        .waddr(row_addr),
        .wdata(row_wdata),
        .raddr(row_addr),
        .rdata(row_rdata)
    );

    blsp_ram #(
        .WIDTH(32),
        .DEPTH(MAX_STEPS + 1)
    ) u_prem_ram (
        .clk  (clk),
        .we   (cmd.prem_we),
        .waddr(prem_waddr),
        .wdata(prem_wdata),
        .raddr(prem_raddr),
        .rdata(prem_rdata)
    );

    blsp_ram #(
        .WIDTH(17),
        .DEPTH(MAX_DATES)
    ) u_date_ram (
        .clk  (clk),
        .we   (cmd.date_we),
        .waddr(date_waddr),
        .wdata({date_day, direction}),
        .raddr(date_raddr),
        .rdata(date_rdata)
    );

endmodule

`default_nettype wire

@@ sv/binomial_lattice_slalom_pricer.sv @@
// Slalom option pricer on a recombining binomial lattice.
// A request is taken when start is high and busy is low; opcode selects
// append date, compute price or clear dates. Append and clear finish in the
// accepting cycle and give no result; further requests may follow at once.
// A compute gives one result: done pulses for one cycle with option_value
// and error_flag. With no dates loaded the result comes in the next cycle,
// with error_flag set, and busy never rises.
// Otherwise a compute keeps busy high while it builds the lattice of N steps,
// scans up to D dates per step and walks each node of every row through the
// node loop (ST_N_RD, ST_N_M1, ST_N_M2, ST_N_WR) around the shared asset
// multiplier and the single read port of the node store. The result strobe
// rises in the same cycle as busy falls.
// The receiver cannot stall; done is a single-cycle strobe. Reset clears the
// date count and loads the default register values. The user must write the
// configuration via cfg_we, cfg_addr, cfg_wdata while idle; not enforced.
`default_nettype none

module binomial_lattice_slalom_pricer #(
    parameter int MAX_DATES = blsp_pkg::DEFAULT_MAX_DATES,
    parameter int MAX_STEPS = blsp_pkg::DEFAULT_MAX_STEPS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [1:0]                  opcode,
    input  wire logic [15:0]                 date_day,
    input  wire logic                        direction,
    input  wire logic [15:0]                 today_day,
    input  wire logic                        cfg_we,
    input  wire logic [blsp_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [blsp_pkg::CFG_W-1:0]  cfg_wdata,
    output logic                             done,
    output logic      [31:0]                 option_value,
    output logic                             error_flag
);

    import blsp_pkg::*;

    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int DAW = (MAX_DATES > 1) ? $clog2(MAX_DATES) : 1;

    blsp_cmd_t      cmd;
    blsp_status_t   status;
    logic [SW-1:0]  nsteps;
    logic [SW-1:0]  row_addr;
    logic [SW-1:0]  prem_raddr;
    logic [SW-1:0]  prem_waddr;
    logic [DAW-1:0] date_waddr;
    logic [DAW-1:0] date_raddr;

    blsp_ctrl #(
        .MAX_DATES(MAX_DATES),
        .MAX_STEPS(MAX_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .busy      (busy),
        .done      (done),
        .nsteps    (nsteps),
        .status    (status),
        .cmd       (cmd),
        .row_addr  (row_addr),
        .prem_raddr(prem_raddr),
        .prem_waddr(prem_waddr),
        .date_waddr(date_waddr),
        .date_raddr(date_raddr)
    );

    blsp_dp #(
        .MAX_DATES(MAX_DATES),
        .MAX_STEPS(MAX_STEPS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .date_day    (date_day),
        .direction   (direction),
        .today_day   (today_day),
        .cmd         (cmd),
        .status      (status),
        .nsteps      (nsteps),
        .row_addr    (row_addr),
        .prem_raddr  (prem_raddr),
        .prem_waddr  (prem_waddr),
        .date_waddr  (date_waddr),
        .date_raddr  (date_raddr),
        .option_value(option_value),
        .error_flag  (error_flag)
    );

endmodule

`default_nettype wire
